// ===== sv/bta_pkg.sv =====
// Shared types and constants for the boundary tag allocator.
// Used by every module of the block; depends on nothing.
`default_nettype none
package bta_pkg;

    localparam int REQ_W      = 10;
    localparam int ADDR_W     = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    localparam int POOL_SIZE_RST = 500;
    localparam int MIN_REM_RST   = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_REM   = 1'b1;

    typedef enum logic {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_NO_FIT = 2'd1,
        ST_REJECT = 2'd2
    } t_status;

    typedef struct packed {
        t_action             action;
        logic [REQ_W-1:0]    request_size;
        logic [ADDR_W-1:0]   block_address;
    } t_item;

    typedef struct packed {
        t_status             status;
        logic [ADDR_W-1:0]   granted_address;
        logic [REQ_W-1:0]    granted_size;
    } t_result;

    typedef enum logic [1:0] {
        ALU_ADD   = 2'd0,
        ALU_SUB   = 2'd1,
        ALU_ADDM1 = 2'd2
    } t_alu_op;

    // Per-field write enables of the unit record memory.
    typedef struct packed {
        logic used;
        logic size;
        logic back;
        logic fwd;
        logic up;
    } t_rec_we;

    typedef enum logic [5:0] {
        S_CLEAR, S_FORMAT, S_IDLE,
        S_A_WALK, S_A_CMP, S_A_UNL1, S_A_UNL2, S_A_SPLIT2, S_A_WDONE, S_A_SDONE,
        S_SB_HEAD, S_SB_FOOT,
        S_F_HEAD, S_F_FADR, S_F_RADR, S_F_FOOT, S_F_LEFT, S_F_RIGHT,
        S_F_CLRP, S_F_CLRF,
        S_F_N_RD, S_F_N_W2, S_F_N_W3,
        S_F_L_RD, S_F_L_UP,
        S_F_R_W2, S_F_R_W3, S_F_R_SZ, S_F_R_UT, S_F_R_UP,
        S_F_B_W2, S_F_B_RD, S_F_B_SZ, S_F_B_FT, S_F_B_UP
    } t_state;

endpackage
`default_nettype wire

// ===== sv/bta_alu.sv =====
// Shared adder and comparator of the allocator sequencer.
// Depends on bta_pkg for the operation codes.
`default_nettype none
module bta_alu
    import bta_pkg::*;
#(
    parameter int W = 11
) (
    input  wire t_alu_op        i_op,
    input  wire logic [W-1:0]   i_a,
    input  wire logic [W-1:0]   i_b,
    output logic [W-1:0]        o_y,
    output logic                o_ge
);

    logic [W:0] diff;

    assign diff = {1'b0, i_a} - {1'b0, i_b};
    assign o_ge = ~diff[W];

    always_comb begin
        unique case (i_op)
            ALU_ADD:   o_y = i_a + i_b;
            ALU_SUB:   o_y = diff[W-1:0];
            ALU_ADDM1: o_y = i_a + i_b - W'(1);
            default:   o_y = i_a + i_b;
        endcase
    end

endmodule
`default_nettype wire

// ===== sv/bta_recmem.sv =====
// Unit record memory: used flag, size, back link, forward link, footer uplink.
// One write address with per-field enables, one registered read. Uses bta_pkg.
`default_nettype none
module bta_recmem
    import bta_pkg::*;
#(
    parameter int N  = 512,
    parameter int AW = 9,
    parameter int SW = 10
) (
    input  wire logic            i_clk,
    input  wire t_rec_we         i_we,
    input  wire logic [AW-1:0]   i_waddr,
    input  wire logic            i_w_used,
    input  wire logic [SW-1:0]   i_w_size,
    input  wire logic [AW-1:0]   i_w_back,
    input  wire logic [AW-1:0]   i_w_fwd,
    input  wire logic [AW-1:0]   i_w_up,
    input  wire logic [AW-1:0]   i_raddr,
    output logic                 o_r_used,
    output logic [SW-1:0]        o_r_size,
    output logic [AW-1:0]        o_r_back,
    output logic [AW-1:0]        o_r_fwd,
    output logic [AW-1:0]        o_r_up
);

    logic          m_used [N];
    logic [SW-1:0] m_size [N];
    logic [AW-1:0] m_back [N];
    logic [AW-1:0] m_fwd  [N];
    logic [AW-1:0] m_up   [N];

    always_ff @(posedge i_clk) begin
        if (i_we.used) m_used[i_waddr] <= i_w_used;
        if (i_we.size) m_size[i_waddr] <= i_w_size;
        if (i_we.back) m_back[i_waddr] <= i_w_back;
        if (i_we.fwd)  m_fwd[i_waddr]  <= i_w_fwd;
        if (i_we.up)   m_up[i_waddr]   <= i_w_up;
        o_r_used <= m_used[i_raddr];
        o_r_size <= m_size[i_raddr];
        o_r_back <= m_back[i_raddr];
        o_r_fwd  <= m_fwd[i_raddr];
        o_r_up   <= m_up[i_raddr];
    end

endmodule
`default_nettype wire

// ===== sv/boundary_tag_allocator_core.sv =====
// Boundary tag first-fit allocator, sequencer over a record memory and a shared adder.
// Allocate walks the free list first-fit from the rover, then tags the granted block.
// Free is rejected or coalesced by neighbour case; one item at a time.
// Reset and every pool_size write start a clearing pass with busy high;
// the result strobe follows the last step and cannot be stalled.
// Depends on bta_pkg, bta_alu and bta_recmem.
`default_nettype none
module boundary_tag_allocator_core
    import bta_pkg::*;
#(
    parameter int POOL_UNITS = 512
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire t_item                  i_item,
    output logic                        o_done,
    output t_result                     o_result,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int AW = $clog2(POOL_UNITS);
    localparam int SW = $clog2(POOL_UNITS + 1);
    localparam int XW = ((SW > REQ_W) ? SW : REQ_W) + 1;
    localparam int RST_POOL = (POOL_SIZE_RST > POOL_UNITS) ? POOL_UNITS : POOL_SIZE_RST;

    t_state r_state, n_state, r_ret, n_ret;
    logic [SW-1:0]     r_pool, n_pool;
    logic [REQ_W-1:0]  r_minrem, n_minrem;
    logic [AW-1:0]     r_rover, n_rover;
    logic              r_empty, n_empty;
    logic [AW-1:0]     r_clr, n_clr;
    logic [AW-1:0]     r_k, n_k;
    logic [AW-1:0]     r_p, n_p;
    logic [XW-1:0]     r_n, n_n;
    logic [SW-1:0]     r_szp, n_szp;
    logic [AW-1:0]     r_nx, n_nx;
    logic [AW-1:0]     r_b, n_b;
    logic [AW-1:0]     r_a, n_a;
    logic [AW-1:0]     r_f, n_f;
    logic [SW-1:0]     r_r, n_r;
    logic [AW-1:0]     r_s, n_s;
    logic [AW-1:0]     r_t, n_t;
    logic [AW-1:0]     r_q, n_q;
    logic [XW-1:0]     r_rem, n_rem;
    logic [XW-1:0]     r_room, n_room;
    logic [SW-1:0]     r_szt, n_szt;
    logic [XW-1:0]     r_sum, n_sum;
    logic              r_lfree, n_lfree;
    logic              r_rfree, n_rfree;
    logic [AW-1:0]     r_sb_h, n_sb_h;
    logic [SW-1:0]     r_sb_sz, n_sb_sz;
    logic              r_sb_used, n_sb_used;
    logic [AW-1:0]     r_sbf, n_sbf;
    t_result           r_res, n_res;
    logic              r_done, n_done;

    t_alu_op           alu_op;
    logic [XW-1:0]     alu_a, alu_b, alu_y;
    logic              alu_ge;

    t_rec_we           we;
    logic [AW-1:0]     waddr, raddr;
    logic              w_used;
    logic [SW-1:0]     w_size;
    logic [AW-1:0]     w_back, w_fwd, w_up;
    logic              rd_used;
    logic [SW-1:0]     rd_size;
    logic [AW-1:0]     rd_back, rd_fwd, rd_up;
    logic [XW-1:0]     cfg_v;

    bta_alu #(.W(XW)) u_alu (
        .i_op (alu_op),
        .i_a  (alu_a),
        .i_b  (alu_b),
        .o_y  (alu_y),
        .o_ge (alu_ge)
    );

    bta_recmem #(.N(POOL_UNITS), .AW(AW), .SW(SW)) u_mem (
        .i_clk    (i_clk),
        .i_we     (we),
        .i_waddr  (waddr),
        .i_w_used (w_used),
        .i_w_size (w_size),
        .i_w_back (w_back),
        .i_w_fwd  (w_fwd),
        .i_w_up   (w_up),
        .i_raddr  (raddr),
        .o_r_used (rd_used),
        .o_r_size (rd_size),
        .o_r_back (rd_back),
        .o_r_fwd  (rd_fwd),
        .o_r_up   (rd_up)
    );

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_done;
    assign o_result    = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_ret    <= S_IDLE;
            r_pool   <= SW'(RST_POOL);
            r_minrem <= REQ_W'(MIN_REM_RST);
            r_rover  <= '0;
            r_empty  <= 1'b0;
            r_clr    <= '0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_pool   <= n_pool;
            r_minrem <= n_minrem;
            r_rover  <= n_rover;
            r_empty  <= n_empty;
            r_clr    <= n_clr;
            r_done   <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k       <= n_k;
        r_p       <= n_p;
        r_n       <= n_n;
        r_szp     <= n_szp;
        r_nx      <= n_nx;
        r_b       <= n_b;
        r_a       <= n_a;
        r_f       <= n_f;
        r_r       <= n_r;
        r_s       <= n_s;
        r_t       <= n_t;
        r_q       <= n_q;
        r_rem     <= n_rem;
        r_room    <= n_room;
        r_szt     <= n_szt;
        r_sum     <= n_sum;
        r_lfree   <= n_lfree;
        r_rfree   <= n_rfree;
        r_sb_h    <= n_sb_h;
        r_sb_sz   <= n_sb_sz;
        r_sb_used <= n_sb_used;
        r_sbf     <= n_sbf;
        r_res     <= n_res;
    end

    always_comb begin
        n_state = r_state;   n_ret = r_ret;       n_pool = r_pool;
        n_minrem = r_minrem; n_rover = r_rover;   n_empty = r_empty;
        n_clr = r_clr;       n_k = r_k;           n_p = r_p;
        n_n = r_n;           n_szp = r_szp;       n_nx = r_nx;
        n_b = r_b;           n_a = r_a;           n_f = r_f;
        n_r = r_r;           n_s = r_s;           n_t = r_t;
        n_q = r_q;           n_rem = r_rem;       n_room = r_room;
        n_szt = r_szt;       n_sum = r_sum;       n_lfree = r_lfree;
        n_rfree = r_rfree;   n_sb_h = r_sb_h;     n_sb_sz = r_sb_sz;
        n_sb_used = r_sb_used; n_sbf = r_sbf;     n_res = r_res;
        n_done = 1'b0;
        alu_op = ALU_ADD;    alu_a = '0;          alu_b = '0;
        we = '0;             waddr = r_p;         raddr = r_p;
        w_used = 1'b0;       w_size = '0;         w_back = '0;
        w_fwd = '0;          w_up = '0;
        cfg_v = '0;

        unique case (r_state)
            S_CLEAR: begin
                we = '1;
                waddr = r_clr;
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(POOL_UNITS - 1)) begin
                    n_state = S_FORMAT;
                end
            end
            S_FORMAT: begin
                we.size = 1'b1;
                waddr = '0;
                w_size = r_pool;
                n_rover = '0;
                n_empty = 1'b0;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    n_res = '0;
                    n_res.status = ST_DONE;
                    if (i_item.action == ACT_ALLOC) begin
                        n_n = (i_item.request_size == '0) ? XW'(1)
                                                          : XW'(i_item.request_size);
                        n_p = r_rover;
                        raddr = r_rover;
                        n_k = '0;
                        if (r_empty) begin
                            n_res.status = ST_NO_FIT;
                            n_done = 1'b1;
                        end else begin
                            n_state = S_A_WALK;
                        end
                    end else begin
                        alu_op = ALU_SUB;
                        alu_a = XW'(r_pool);
                        alu_b = XW'(i_item.block_address);
                        n_p = AW'(i_item.block_address);
                        raddr = AW'(i_item.block_address);
                        n_room = alu_y;
                        if (alu_ge && alu_y != '0) begin
                            n_state = S_F_HEAD;
                        end else begin
                            n_res.status = ST_REJECT;
                            n_done = 1'b1;
                        end
                    end
                end
            end
            // First-fit walk: one free block per cycle.
            S_A_WALK: begin
                alu_op = ALU_SUB;
                alu_a = XW'(rd_size);
                alu_b = r_n;
                if (alu_ge) begin
                    n_szp = rd_size;
                    n_nx = rd_fwd;
                    n_b = rd_back;
                    n_rem = alu_y;
                    n_state = S_A_CMP;
                end else if (rd_fwd == r_rover || r_k == AW'(POOL_UNITS - 1)) begin
                    n_res.status = ST_NO_FIT;
                    n_done = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_p = rd_fwd;
                    raddr = rd_fwd;
                    n_k = r_k + AW'(1);
                end
            end
            S_A_CMP: begin
                alu_op = ALU_SUB;
                alu_a = XW'(r_minrem);
                alu_b = r_rem;
                if (alu_ge) begin
                    n_sb_h = r_p;
                    n_sb_sz = r_szp;
                    n_sb_used = 1'b1;
                    n_ret = S_A_WDONE;
                    if (r_nx == r_p) begin
                        n_empty = 1'b1;
                        n_state = S_SB_HEAD;
                    end else begin
                        n_state = S_A_UNL1;
                    end
                end else begin
                    n_sb_h = r_p;
                    n_sb_sz = SW'(r_rem);
                    n_sb_used = 1'b0;
                    n_ret = S_A_SPLIT2;
                    n_state = S_SB_HEAD;
                end
            end
            S_A_UNL1: begin
                we.back = 1'b1;
                waddr = r_nx;
                w_back = r_b;
                n_state = S_A_UNL2;
            end
            S_A_UNL2: begin
                we.fwd = 1'b1;
                waddr = r_b;
                w_fwd = r_nx;
                n_state = S_SB_HEAD;
            end
            S_A_SPLIT2: begin
                alu_op = ALU_ADD;
                alu_a = XW'(r_p);
                alu_b = r_rem;
                n_q = AW'(alu_y);
                n_sb_h = AW'(alu_y);
                n_sb_sz = SW'(r_n);
                n_sb_used = 1'b1;
                n_ret = S_A_SDONE;
                n_state = S_SB_HEAD;
            end
            S_A_WDONE: begin
                n_rover = r_nx;
                n_res.granted_address = ADDR_W'(r_p);
                n_res.granted_size = REQ_W'(r_szp);
                n_done = 1'b1;
                n_state = S_IDLE;
            end
            S_A_SDONE: begin
                n_rover = r_nx;
                n_res.granted_address = ADDR_W'(r_q);
                n_res.granted_size = REQ_W'(r_n);
                n_done = 1'b1;
                n_state = S_IDLE;
            end
            // Writes the head and foot tags of one block, then returns.
            S_SB_HEAD: begin
                we.size = 1'b1;
                we.used = 1'b1;
                waddr = r_sb_h;
                w_size = r_sb_sz;
                w_used = r_sb_used;
                alu_op = ALU_ADDM1;
                alu_a = XW'(r_sb_h);
                alu_b = XW'(r_sb_sz);
                n_sbf = AW'(alu_y);
                n_state = S_SB_FOOT;
            end
            S_SB_FOOT: begin
                we.used = 1'b1;
                we.up = 1'b1;
                waddr = r_sbf;
                w_used = r_sb_used;
                w_up = r_sb_h;
                n_state = r_ret;
            end
            S_F_HEAD: begin
                alu_op = ALU_SUB;
                alu_a = r_room;
                alu_b = XW'(rd_size);
                n_n = XW'(rd_size);
                if (!rd_used || rd_size == '0 || !alu_ge) begin
                    n_res.status = ST_REJECT;
                    n_done = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_F_FADR;
                end
            end
            S_F_FADR: begin
                alu_op = ALU_ADDM1;
                alu_a = XW'(r_p);
                alu_b = r_n;
                n_f = AW'(alu_y);
                n_state = S_F_RADR;
            end
            S_F_RADR: begin
                alu_op = ALU_ADD;
                alu_a = XW'(r_p);
                alu_b = r_n;
                n_r = SW'(alu_y);
                raddr = r_f;
                n_state = S_F_FOOT;
            end
            S_F_FOOT: begin
                alu_op = ALU_SUB;
                alu_a = XW'(r_p);
                alu_b = XW'(1);
                raddr = AW'(alu_y);
                if (!rd_used || rd_up != r_p) begin
                    n_res.status = ST_REJECT;
                    n_done = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_F_LEFT;
                end
            end
            S_F_LEFT: begin
                n_lfree = (r_p != '0) && !rd_used;
                n_s = rd_up;
                raddr = AW'(r_r);
                n_state = S_F_RIGHT;
            end
            S_F_RIGHT: begin
                n_rfree = (r_r != r_pool) && !rd_used;
                n_t = AW'(r_r);
                n_b = rd_back;
                n_a = rd_fwd;
                n_szt = rd_size;
                n_state = S_F_CLRP;
            end
            S_F_CLRP: begin
                we.used = 1'b1;
                waddr = r_p;
                n_state = S_F_CLRF;
            end
            // The foot already points to the head, so rewriting the uplink is harmless.
            S_F_CLRF: begin
                we.used = 1'b1;
                we.up = 1'b1;
                waddr = r_f;
                w_up = r_p;
                priority if (!r_lfree && !r_rfree) begin
                    raddr = r_rover;
                    n_state = r_empty ? S_F_N_W3 : S_F_N_RD;
                end else if (r_lfree && !r_rfree) begin
                    raddr = r_s;
                    n_state = S_F_L_RD;
                end else if (!r_lfree && r_rfree) begin
                    n_state = S_F_R_W2;
                end else begin
                    n_state = S_F_B_W2;
                end
            end
            S_F_N_RD: begin
                we.fwd = 1'b1;
                we.back = 1'b1;
                waddr = r_p;
                w_fwd = r_rover;
                w_back = rd_back;
                n_b = rd_back;
                n_state = S_F_N_W2;
            end
            S_F_N_W2: begin
                we.fwd = 1'b1;
                waddr = r_b;
                w_fwd = r_p;
                n_state = S_F_N_W3;
            end
            // Either links the block in just before the rover or makes it a one-block list.
            S_F_N_W3: begin
                if (r_empty) begin
                    we.fwd = 1'b1;
                    we.back = 1'b1;
                    waddr = r_p;
                    w_fwd = r_p;
                    w_back = r_p;
                    n_empty = 1'b0;
                end else begin
                    we.back = 1'b1;
                    waddr = r_rover;
                    w_back = r_p;
                end
                n_rover = r_p;
                n_done = 1'b1;
                n_state = S_IDLE;
            end
            S_F_L_RD: begin
                alu_op = ALU_ADD;
                alu_a = XW'(rd_size);
                alu_b = r_n;
                we.size = 1'b1;
                waddr = r_s;
                w_size = SW'(alu_y);
                n_state = S_F_L_UP;
            end
            S_F_L_UP: begin
                we.up = 1'b1;
                waddr = r_f;
                w_up = r_s;
                n_done = 1'b1;
                n_state = S_IDLE;
            end
            S_F_R_W2: begin
                we.fwd = 1'b1;
                we.back = 1'b1;
                waddr = r_p;
                if (r_a == r_t) begin
                    w_fwd = r_p;
                    w_back = r_p;
                    n_state = S_F_R_SZ;
                end else begin
                    w_fwd = r_a;
                    w_back = r_b;
                    n_state = S_F_R_W3;
                end
            end
            S_F_R_W3: begin
                we.fwd = 1'b1;
                waddr = r_b;
                w_fwd = r_p;
                n_state = S_F_B_W2;
                n_ret = S_F_R_SZ;
            end
            S_F_R_SZ: begin
                alu_op = ALU_ADD;
                alu_a = r_n;
                alu_b = XW'(r_szt);
                we.size = 1'b1;
                waddr = r_p;
                w_size = SW'(alu_y);
                n_sum = alu_y;
                n_state = S_F_R_UT;
            end
            S_F_R_UT: begin
                we.used = 1'b1;
                waddr = r_t;
                alu_op = ALU_ADDM1;
                alu_a = XW'(r_p);
                alu_b = r_sum;
                n_f = AW'(alu_y);
                n_state = S_F_R_UP;
            end
            S_F_R_UP: begin
                we.up = 1'b1;
                waddr = r_f;
                w_up = r_p;
                if (r_rover == r_t) begin
                    n_rover = r_p;
                end
                n_done = 1'b1;
                n_state = S_IDLE;
            end
            // Unlinks the right neighbour (both free), or finishes relinking (right only).
            S_F_B_W2: begin
                if (r_lfree) begin
                    if (r_state == S_F_B_W2) begin
                        we.fwd = 1'b1;
                        waddr = r_b;
                        w_fwd = r_a;
                    end
                    n_state = S_F_B_RD;
                end else begin
                    we.back = 1'b1;
                    waddr = r_a;
                    w_back = r_p;
                    n_state = S_F_R_SZ;
                end
            end
            // The return state also marks the foot-address step of S_F_B_UP, before its write.
            S_F_B_RD: begin
                we.back = 1'b1;
                waddr = r_a;
                w_back = r_b;
                raddr = r_s;
                n_ret = S_F_B_SZ;
                n_state = S_F_B_SZ;
            end
            S_F_B_SZ: begin
                alu_op = ALU_ADD;
                alu_a = XW'(rd_size);
                alu_b = r_n;
                n_sum = alu_y;
                n_state = S_F_B_FT;
            end
            S_F_B_FT: begin
                alu_op = ALU_ADD;
                alu_a = r_sum;
                alu_b = XW'(r_szt);
                we.size = 1'b1;
                waddr = r_s;
                w_size = SW'(alu_y);
                n_sum = alu_y;
                n_state = S_F_B_UP;
            end
            S_F_B_UP: begin
                if (r_ret == S_F_B_UP) begin
                    we.up = 1'b1;
                    waddr = r_f;
                    w_up = r_s;
                    if (r_rover == r_t) begin
                        n_rover = r_s;
                    end
                    n_done = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    alu_op = ALU_ADDM1;
                    alu_a = XW'(r_s);
                    alu_b = r_sum;
                    n_f = AW'(alu_y);
                    n_ret = S_F_B_UP;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // The user writes configuration only while idle; the block does not enforce it. A pool size write reformats.
        if (i_cfg_valid) begin
            if (i_cfg_index == CFG_POOL_SIZE) begin
                cfg_v = XW'(i_cfg_data);
                if (cfg_v == '0) begin
                    cfg_v = XW'(1);
                end else if (cfg_v > XW'(POOL_UNITS)) begin
                    cfg_v = XW'(POOL_UNITS);
                end
                n_pool = SW'(cfg_v);
                n_clr = '0;
                n_rover = '0;
                n_empty = 1'b0;
                n_state = S_CLEAR;
            end else begin
                n_minrem = REQ_W'(i_cfg_data);
            end
        end
    end

endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for boundary_tag_allocator_core: directed and random
// allocate/free items, checked against an in-bench allocator predictor.
// Depends on bta_pkg and the allocator RTL.
`timescale 1ns / 100ps
module tb;
    import bta_pkg::*;

    localparam int UNITS = 512;
    localparam int CYCLE_LIMIT = 2000000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    t_item                  i_item = '0;
    logic                   o_done;
    t_result                o_result;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    boundary_tag_allocator_core #(.POOL_UNITS(UNITS)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_done(o_done), .o_result(o_result),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 0;
    end

    // Allocator shadow state.
    bit          rec_used [UNITS];
    int unsigned rec_size [UNITS];
    int unsigned rec_back [UNITS];
    int unsigned rec_fwd  [UNITS];
    int unsigned rec_up   [UNITS];
    int unsigned pool_units;
    int unsigned min_rem;
    int unsigned rover;
    bit          list_empty;

    t_result pending_results[$];
    int unsigned live_blocks[$];
    int mismatches = 0;
    int cycles = 0;
    int send_gap_pct = 0;

    function automatic int unsigned ix(int unsigned a);
        return a < UNITS ? a : 0;
    endfunction

    function automatic int unsigned foot_of(int unsigned h);
        h = ix(h);
        return ix(h + rec_size[h] - 1);
    endfunction

    function automatic void format_pool();
        for (int i = 0; i < UNITS; i++) begin
            rec_used[i] = 0;
            rec_size[i] = 0;
            rec_back[i] = 0;
            rec_fwd[i] = 0;
            rec_up[i] = 0;
        end
        rec_size[0] = pool_units;
        rec_up[ix(pool_units - 1)] = 0;
        rover = 0;
        list_empty = 0;
    endfunction

    function automatic void mark_block(int unsigned h, int unsigned sz, bit used);
        int unsigned f;
        h = ix(h);
        rec_size[h] = sz;
        rec_used[h] = used;
        f = foot_of(h);
        rec_used[f] = used;
        rec_up[f] = h;
    endfunction

    function automatic t_result first_fit(int unsigned n);
        t_result r;
        int unsigned p, nx, q, b;
        bit found;
        r = '{status: ST_NO_FIT, granted_address: '0, granted_size: '0};
        found = 0;
        if (n == 0) n = 1;
        if (list_empty) return r;
        p = ix(rover);
        for (int k = 0; k < UNITS; k++) begin
            if (rec_size[p] >= n) begin
                found = 1;
                break;
            end
            p = ix(rec_fwd[p]);
            if (p == ix(rover)) break;
        end
        if (!found) return r;
        nx = ix(rec_fwd[p]);
        r.status = ST_DONE;
        if (rec_size[p] - n <= min_rem) begin
            if (nx == p) begin
                list_empty = 1;
            end else begin
                b = ix(rec_back[p]);
                rec_back[nx] = b;
                rec_fwd[b] = nx;
            end
            mark_block(p, rec_size[p], 1);
            rover = nx;
            r.granted_address = p[ADDR_W-1:0];
            r.granted_size = rec_size[p][REQ_W-1:0];
            return r;
        end
        rec_size[p] -= n;
        mark_block(p, rec_size[p], 0);
        q = ix(p + rec_size[p]);
        mark_block(q, n, 1);
        rover = nx;
        r.granted_address = q[ADDR_W-1:0];
        r.granted_size = n[REQ_W-1:0];
        return r;
    endfunction

    function automatic t_status release_block(int unsigned p);
        int unsigned n, f, rt, s, b, a;
        bit lfree, rfree;
        if (p >= pool_units || !rec_used[p]) return ST_REJECT;
        n = rec_size[p];
        if (n == 0 || n > pool_units - p) return ST_REJECT;
        f = p + n - 1;
        if (!rec_used[f] || rec_up[f] != p) return ST_REJECT;
        rt = p + n;
        lfree = p > 0 && !rec_used[p - 1];
        rfree = rt < pool_units && !rec_used[rt];
        rec_used[p] = 0;
        rec_used[f] = 0;
        if (!lfree && !rfree) begin
            rec_up[f] = p;
            if (list_empty) begin
                rec_back[p] = p;
                rec_fwd[p] = p;
                list_empty = 0;
            end else begin
                a = ix(rover);
                b = ix(rec_back[a]);
                rec_fwd[p] = a;
                rec_back[p] = b;
                rec_fwd[b] = p;
                rec_back[a] = p;
            end
            rover = p;
        end else if (lfree && !rfree) begin
            s = ix(rec_up[p - 1]);
            rec_size[s] += n;
            rec_up[f] = s;
        end else if (!lfree && rfree) begin
            b = ix(rec_back[rt]);
            a = ix(rec_fwd[rt]);
            if (a == rt) begin
                rec_back[p] = p;
                rec_fwd[p] = p;
            end else begin
                rec_back[p] = b;
                rec_fwd[b] = p;
                rec_fwd[p] = a;
                rec_back[a] = p;
            end
            rec_size[p] = n + rec_size[rt];
            rec_used[rt] = 0;
            rec_up[foot_of(p)] = p;
            if (ix(rover) == rt) rover = p;
        end else begin
            s = ix(rec_up[p - 1]);
            b = ix(rec_back[rt]);
            a = ix(rec_fwd[rt]);
            rec_fwd[b] = a;
            rec_back[a] = b;
            rec_size[s] += n + rec_size[rt];
            rec_up[foot_of(s)] = s;
            if (ix(rover) == rt) rover = s;
        end
        return ST_DONE;
    endfunction

    function automatic t_result predict_item(t_item it);
        t_result r;
        r = '0;
        if (it.action == ACT_ALLOC) begin
            r = first_fit(it.request_size);
            if (r.status == ST_DONE) live_blocks.push_back(r.granted_address);
        end else begin
            r.status = release_block(it.block_address);
            if (r.status == ST_DONE)
                foreach (live_blocks[i])
                    if (live_blocks[i] == it.block_address) begin
                        live_blocks.delete(i);
                        break;
                    end
        end
        return r;
    endfunction

    // Checker: outputs are sampled at the falling edge, away from the driving edge.
    always @(negedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: unexpected result %p", o_result);
            end else begin
                want = pending_results.pop_front();
                if (o_result.status !== want.status
                        || o_result.granted_address !== want.granted_address
                        || o_result.granted_size !== want.granted_size) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("tb: mismatch expected %p actual %p", want, o_result);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // Sends one item; start stays high afterwards unless the next call idles.
    task automatic send_item(t_action act, int unsigned req, int unsigned addr);
        t_item it;
        it.action = act;
        it.request_size = req[REQ_W-1:0];
        it.block_address = addr[ADDR_W-1:0];
        while ($urandom_range(99) < send_gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_item <= it;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        pending_results.push_back(predict_item(it));
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
        int unsigned v;
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value[CFG_DATA_W-1:0];
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        v = value & 10'h3FF;
        if (idx == CFG_POOL_SIZE) begin
            if (v == 0) v = 1;
            if (v > UNITS) v = UNITS;
            pool_units = v;
            format_pool();
            live_blocks.delete();
        end else begin
            min_rem = v;
        end
    endtask

    task automatic test_reset_pool();
        send_item(ACT_ALLOC, 0, 0);
        send_item(ACT_ALLOC, 512, 0);
        send_item(ACT_ALLOC, 1023, 511);
        send_item(ACT_ALLOC, 480, 0);
        send_item(ACT_FREE, 0, 511);
        send_item(ACT_FREE, 0, 0);
        send_item(ACT_FREE, 0, 499);
        send_item(ACT_FREE, 0, 480);
        send_item(ACT_ALLOC, 30, 0);
    endtask

    // Four neighbors: this order frees with no free neighbour, with both free, then a double free.
    task automatic test_coalesce();
        write_reg(CFG_MIN_REM, 0);
        write_reg(CFG_POOL_SIZE, 64);
        repeat (4) send_item(ACT_ALLOC, 10, 0);
        send_item(ACT_FREE, 0, 54);
        send_item(ACT_FREE, 0, 34);
        send_item(ACT_FREE, 0, 44);
        send_item(ACT_FREE, 0, 24);
        send_item(ACT_FREE, 0, 44);
    endtask

    task automatic test_empty_list();
        write_reg(CFG_POOL_SIZE, 0);
        send_item(ACT_ALLOC, 1, 0);
        send_item(ACT_ALLOC, 1, 0);
        send_item(ACT_FREE, 0, 0);
        write_reg(CFG_POOL_SIZE, 1023);
        write_reg(CFG_MIN_REM, 1023);
        send_item(ACT_ALLOC, 5, 0);
        send_item(ACT_ALLOC, 5, 0);
        send_item(ACT_FREE, 0, 0);
    endtask

    task automatic test_random(int count);
        int unsigned req;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 55) begin
                case ($urandom_range(9))
                    0:       req = $urandom_range(1023);
                    1:       req = $urandom_range(512, 100);
                    default: req = $urandom_range(40);
                endcase
                send_item(ACT_ALLOC, req, $urandom_range(511));
            end else if (live_blocks.size() != 0 && $urandom_range(99) < 80) begin
                send_item(ACT_FREE, $urandom_range(1023),
                          live_blocks[$urandom_range(live_blocks.size() - 1)]);
            end else begin
                send_item(ACT_FREE, $urandom_range(1023), $urandom_range(511));
            end
        end
    endtask

    initial begin
        pool_units = POOL_SIZE_RST;
        min_rem = MIN_REM_RST;
        format_pool();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_pool();
        test_coalesce();
        test_empty_list();
        send_gap_pct = 26;
        write_reg(CFG_MIN_REM, 4);
        write_reg(CFG_POOL_SIZE, 300);
        test_random(130);
        wait_drained();
        send_gap_pct = 57;
        write_reg(CFG_MIN_REM, 0);
        write_reg(CFG_POOL_SIZE, 512);
        test_random(130);
        send_gap_pct = 0;
        write_reg(CFG_MIN_REM, $urandom_range(20));
        write_reg(CFG_POOL_SIZE, $urandom_range(100, 400));
        test_random(130);
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule

// ===== files.f =====
sv/bta_pkg.sv
sv/bta_alu.sv
sv/bta_recmem.sv
sv/boundary_tag_allocator_core.sv
test/tb.sv
